// ===== src/shhf_pkg.sv =====
// Shared types and constants for the sketch heavy hitter flag unit.
package shhf_pkg;

   localparam int PORT_W = 16;
   localparam int THR_W = 16;
   localparam int NUM_ROWS = 3;
   localparam int CSR_INDEX_W = 2;

   localparam logic [THR_W-1:0] LOW_THRESHOLD_RESET = 16'd100;
   localparam logic [THR_W-1:0] HIGH_THRESHOLD_RESET = 16'd1000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LOW_THRESHOLD  = 2'd0,
      CSR_HIGH_THRESHOLD = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic [THR_W-1:0] low;
      logic [THR_W-1:0] high;
   } thresh_type;

endpackage

// ===== src/shhf_index.sv =====
// Pipelined port hash: signed product check and constant modulo reductions.
module shhf_index #(
   parameter int HASH_MODULUS = 256,
   parameter int TABLE_DEPTH = 4096,
   parameter int IW = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [shhf_pkg::PORT_W-1:0]  source_port,
   input  logic [shhf_pkg::PORT_W-1:0]  dest_port,
   output logic                         out_valid,
   output logic [IW-1:0]                out_index,
   input  logic                         out_ready
);
   import shhf_pkg::*;

   localparam int NS = 8;
   localparam int MW = $clog2(HASH_MODULUS);
   localparam int PW = 2 * MW;
   localparam int DW = ((MW > IW) ? MW : IW) + 1;
   localparam int RECIP_A = (2 ** PORT_W) / HASH_MODULUS;
   localparam int RECIP_P = (2 ** PW) / HASH_MODULUS;
   localparam int RECIP_D = (2 ** MW) / TABLE_DEPTH;

   logic [NS:1]   v_ff;
   logic [NS+1:1] en;

   logic [PORT_W-1:0] s1_a_ff, s1_b_ff;
   logic              s2_neg_ff;
   logic [PORT_W-1:0] s2_a_ff, s2_b_ff, s2_qa_ff, s2_qb_ff;
   logic              s3_neg_ff;
   logic [MW-1:0]     s3_ra_ff, s3_rb_ff;
   logic              s4_neg_ff;
   logic [PW-1:0]     s4_rp_ff;
   logic              s5_neg_ff;
   logic [PW-1:0]     s5_rp_ff, s5_qp_ff;
   logic [MW-1:0]     s6_hm_ff;
   logic [MW-1:0]     s7_hm_ff, s7_qd_ff;
   logic [IW-1:0]     s8_idx_ff;

   logic [2*PORT_W-1:0] prod_in, qa_full, qb_full;
   logic [2*PORT_W-1:0] qam, qbm;
   logic [PORT_W-1:0]   da, db;
   logic [MW-1:0]       ra_in, rb_in;
   logic [PW-1:0]       rp_in;
   logic [2*PW-1:0]     qp_full, qpm;
   logic [PW-1:0]       dp;
   logic [MW-1:0]       hm_in;
   logic [2*MW-1:0]     qd_full;
   logic [MW+DW-1:0]    qdm;
   logic [DW-1:0]       dd;
   logic [IW-1:0]       idx_in;

   // Each stage loads when it is empty or the stage after it moves on.
   always_comb begin
      en[NS+1] = out_ready;
      for (int i = NS; i >= 1; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
   end

   assign in_ready = en[1];
   assign out_valid = v_ff[NS];
   assign out_index = s8_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[1]) begin
            v_ff[1] <= in_valid;
         end
         for (int i = 2; i <= NS; i++) begin
            if (en[i]) begin
               v_ff[i] <= v_ff[i-1];
            end
         end
      end
   end

   // Quotient estimates by reciprocal multiply; each is low by at most one.
   always_comb begin
      prod_in = (2*PORT_W)'(s1_a_ff) * (2*PORT_W)'(s1_b_ff);
      qa_full = (2*PORT_W)'(s1_a_ff) * (2*PORT_W)'(RECIP_A);
      qb_full = (2*PORT_W)'(s1_b_ff) * (2*PORT_W)'(RECIP_A);

      qam = (2*PORT_W)'(s2_qa_ff) * (2*PORT_W)'(HASH_MODULUS);
      qbm = (2*PORT_W)'(s2_qb_ff) * (2*PORT_W)'(HASH_MODULUS);
      da = s2_a_ff - qam[PORT_W-1:0];
      db = s2_b_ff - qbm[PORT_W-1:0];
      if (da >= PORT_W'(HASH_MODULUS)) begin
         da = da - PORT_W'(HASH_MODULUS);
      end
      if (db >= PORT_W'(HASH_MODULUS)) begin
         db = db - PORT_W'(HASH_MODULUS);
      end
      ra_in = da[MW-1:0];
      rb_in = db[MW-1:0];

      rp_in = PW'(s3_ra_ff) * PW'(s3_rb_ff);

      qp_full = (2*PW)'(s4_rp_ff) * (2*PW)'(RECIP_P);

      qpm = (2*PW)'(s5_qp_ff) * (2*PW)'(HASH_MODULUS);
      dp = s5_rp_ff - qpm[PW-1:0];
      if (dp >= PW'(HASH_MODULUS)) begin
         dp = dp - PW'(HASH_MODULUS);
      end
      // A product with its top bit set reads as negative and hashes to zero.
      hm_in = s5_neg_ff ? '0 : dp[MW-1:0];

      qd_full = (2*MW)'(s6_hm_ff) * (2*MW)'(RECIP_D);

      qdm = (MW+DW)'(s7_qd_ff) * (MW+DW)'(TABLE_DEPTH);
      dd = DW'(s7_hm_ff) - qdm[DW-1:0];
      if (dd >= DW'(TABLE_DEPTH)) begin
         dd = dd - DW'(TABLE_DEPTH);
      end
      idx_in = dd[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_a_ff <= source_port;
         s1_b_ff <= dest_port;
      end
      if (en[2]) begin
         s2_neg_ff <= prod_in[2*PORT_W-1];
         s2_a_ff <= s1_a_ff;
         s2_b_ff <= s1_b_ff;
         s2_qa_ff <= qa_full[2*PORT_W-1:PORT_W];
         s2_qb_ff <= qb_full[2*PORT_W-1:PORT_W];
      end
      if (en[3]) begin
         s3_neg_ff <= s2_neg_ff;
         s3_ra_ff <= ra_in;
         s3_rb_ff <= rb_in;
      end
      if (en[4]) begin
         s4_neg_ff <= s3_neg_ff;
         s4_rp_ff <= rp_in;
      end
      if (en[5]) begin
         s5_neg_ff <= s4_neg_ff;
         s5_rp_ff <= s4_rp_ff;
         s5_qp_ff <= qp_full[2*PW-1:PW];
      end
      if (en[6]) begin
         s6_hm_ff <= hm_in;
      end
      if (en[7]) begin
         s7_hm_ff <= s6_hm_ff;
         s7_qd_ff <= qd_full[2*MW-1:MW];
      end
      if (en[8]) begin
         s8_idx_ff <= idx_in;
      end
   end

endmodule

// ===== src/shhf_counts.sv =====
// Counter memory with read, threshold check, saturating update and forwarding.
module shhf_counts #(
   parameter int TABLE_DEPTH = 4096,
   parameter int COUNTER_BITS = 16,
   parameter int IW = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   idx_valid,
   output logic                   idx_ready,
   input  logic [IW-1:0]          idx,
   input  shhf_pkg::thresh_type   thresh,
   output logic                   res_valid,
   output logic                   res_flag,
   input  logic                   res_ready,
   output logic                   busy
);
   import shhf_pkg::*;

   localparam int CW = COUNTER_BITS;
   localparam int RW = NUM_ROWS * CW;
   localparam int TW = (CW > THR_W) ? CW : THR_W;

   logic [RW-1:0] mem [TABLE_DEPTH];

   logic          clear_ff;
   logic [IW-1:0] clr_addr_ff;
   logic          m1_v_ff;
   logic [IW-1:0] m1_addr_ff;
   logic [RW-1:0] rdata_ff;
   logic          fwd_v_ff;
   logic [IW-1:0] fwd_addr_ff;
   logic [RW-1:0] fwd_data_ff;

   logic          rd_en, m1_go, wr_en;
   logic [IW-1:0] wr_addr;
   logic [RW-1:0] cur, upd, wr_data;
   logic          all_inside;
   logic [CW-1:0] c;

   assign busy = clear_ff;
   assign idx_ready = !m1_v_ff || res_ready;
   assign rd_en = idx_valid && idx_ready;
   assign m1_go = m1_v_ff && res_ready;
   assign res_valid = m1_v_ff;
   assign res_flag = !all_inside;

   // The newest write always holds the latest value for its entry, so it
   // overrides read data that may predate it.
   assign cur = (fwd_v_ff && (fwd_addr_ff == m1_addr_ff)) ? fwd_data_ff : rdata_ff;

   always_comb begin
      all_inside = 1'b1;
      upd = '0;
      for (int r = 0; r < NUM_ROWS; r++) begin
         c = cur[r*CW +: CW];
         if (!((TW'(c) > TW'(thresh.low)) && (TW'(c) < TW'(thresh.high)))) begin
            all_inside = 1'b0;
         end
         upd[r*CW +: CW] = (c == '1) ? c : c + CW'(1);
      end
   end

   always_comb begin
      priority if (clear_ff) begin
         wr_en = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en = m1_go;
         wr_addr = m1_addr_ff;
         wr_data = upd;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff <= 1'b1;
         clr_addr_ff <= '0;
         m1_v_ff <= 1'b0;
         fwd_v_ff <= 1'b0;
      end else begin
         if (clear_ff) begin
            clr_addr_ff <= clr_addr_ff + IW'(1);
            if (clr_addr_ff == IW'(TABLE_DEPTH - 1)) begin
               clear_ff <= 1'b0;
            end
         end
         if (idx_ready) begin
            m1_v_ff <= idx_valid;
         end
         if (m1_go) begin
            fwd_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         m1_addr_ff <= idx;
      end
      if (m1_go) begin
         fwd_addr_ff <= m1_addr_ff;
         fwd_data_ff <= upd;
      end
   end

endmodule

// ===== src/sketch_heavy_hitter_flag_unit.sv =====
// A request passes the index pipeline, counter read and result registers before
// rsp_valid rises. Throughput: one beat per cycle unless a response stalls; the
// counters are read as the index is taken and written back as the beat leaves,
// the last write forwarded on a match. Reset clears control state, reloads the
// default thresholds, then clears the counter memory one entry per cycle with
// req_ready low. The result register lets a new request in while a result waits.
module sketch_heavy_hitter_flag_unit #(
   parameter int TABLE_DEPTH = 4096,
   parameter int HASH_MODULUS = 256,
   parameter int COUNTER_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [shhf_pkg::PORT_W-1:0]       req_source_port,
   input  logic [shhf_pkg::PORT_W-1:0]       req_dest_port,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_not_heavy_flag,
   input  logic                              csr_wr_en,
   input  logic [shhf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [shhf_pkg::THR_W-1:0]        csr_wdata
);
   import shhf_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);

   thresh_type    thresh_ff;
   logic          rsp_valid_ff;
   logic          rsp_flag_ff;

   logic          busy;
   logic          hash_in_ready;
   logic          idx_valid, idx_ready;
   logic [IW-1:0] idx;
   logic          res_valid, res_flag, out_en;

   assign out_en = !rsp_valid_ff || rsp_ready;
   assign req_ready = hash_in_ready && !busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_not_heavy_flag = rsp_flag_ff;

   shhf_index #(
      .HASH_MODULUS (HASH_MODULUS),
      .TABLE_DEPTH  (TABLE_DEPTH),
      .IW           (IW)
   ) u_index (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid && !busy),
      .in_ready    (hash_in_ready),
      .source_port (req_source_port),
      .dest_port   (req_dest_port),
      .out_valid   (idx_valid),
      .out_index   (idx),
      .out_ready   (idx_ready)
   );

   shhf_counts #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .COUNTER_BITS (COUNTER_BITS),
      .IW           (IW)
   ) u_counts (
      .clock     (clock),
      .reset     (reset),
      .idx_valid (idx_valid),
      .idx_ready (idx_ready),
      .idx       (idx),
      .thresh    (thresh_ff),
      .res_valid (res_valid),
      .res_flag  (res_flag),
      .res_ready (out_en),
      .busy      (busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.low <= LOW_THRESHOLD_RESET;
         thresh_ff.high <= HIGH_THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_LOW_THRESHOLD: begin
                  thresh_ff.low <= csr_wdata;
               end
               CSR_HIGH_THRESHOLD: begin
                  thresh_ff.high <= csr_wdata;
               end
               default: begin
                  thresh_ff <= thresh_ff;
               end
            endcase
         end
         if (out_en) begin
            rsp_valid_ff <= res_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_flag_ff <= res_flag;
      end
   end

endmodule

// ===== src/shhf_checker.sv =====
// Port-level checker for the sketch heavy hitter flag unit, with its bind.
module shhf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_not_heavy_flag
);

   localparam int MAX_IN_FLIGHT = 10;

   logic [4:0] pending_ff;
   logic       req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + 5'(req_beat) - 5'(rsp_beat);
      end
   end

   // The memory clearing pass holds off requests right after reset.
   a_clear_blocks_req: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request taken during memory clear");

   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_not_heavy_flag))
      else $error("stalled response changed");

   // Every response beat answers an earlier request beat.
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 5'd0)
      else $error("response without a pending request");

   a_in_flight_bound: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 5'(MAX_IN_FLIGHT))
      else $error("more beats in flight than pipeline stages");

endmodule

bind sketch_heavy_hitter_flag_unit shhf_checker u_shhf_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_not_heavy_flag (rsp_not_heavy_flag)
);
